/* sv/fpc_pkg.sv */
// ============================================================================
// fpc_pkg: shared types, codes and functions of the pixel converter
// Holds the format and opcode codes, the YUV coefficients and the packing logic.
// ============================================================================
`default_nettype none

package fpc_pkg;

    // Number of palette entries by default.
    localparam int PALETTE_DEPTH_DEFAULT = 256;

    // Input item opcodes.
    localparam logic OP_PIXEL     = 1'b0;
    localparam logic OP_PAL_WRITE = 1'b1;

    // Source formats.
    localparam logic [1:0] FMT_YUV     = 2'd0;
    localparam logic [1:0] FMT_RGB     = 2'd1;
    localparam logic [1:0] FMT_PALETTE = 2'd2;
    localparam logic [1:0] FMT_BW      = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] CFG_OUT_BPP       = 2'd1;
    localparam logic [1:0] CFG_RED_LOW       = 2'd2;

    // Configuration reset values.
    localparam logic [1:0] SOURCE_FORMAT_RST = FMT_YUV;
    localparam logic [2:0] OUT_BPP_RST       = 3'd4;
    localparam logic       RED_LOW_RST       = 1'b0;

    // Output packing modes (bytes per pixel).
    localparam logic [2:0] BPP_GRAY8  = 3'd1;
    localparam logic [2:0] BPP_GRAY16 = 3'd2;
    localparam logic [2:0] BPP_RGB24  = 3'd3;
    localparam logic [2:0] BPP_RGB32  = 3'd4;

    // Q16 color coefficients. The largest one needs a 19-bit signed field.
    localparam logic signed [18:0] K_RU = 19'sd3;
    localparam logic signed [18:0] K_RV = 19'sd74711;
    localparam logic signed [18:0] K_GU = 19'sd25887;
    localparam logic signed [18:0] K_GV = 19'sd38076;
    localparam logic signed [18:0] K_BU = 19'sd133169;
    localparam logic signed [18:0] K_BV = 19'sd33;

    // Reciprocal of three in Q11; exact floor for sums up to 765.
    localparam logic [9:0] RECIP3_Q11 = 10'd683;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        logic [2:0] bpp;
        logic       red_low;
    } pack_cfg_t;

    function automatic logic [7:0] gray3(input rgb_t px);
        logic [9:0]  sum;
        logic [19:0] prod;
        begin
            sum  = 10'(px.r) + 10'(px.g) + 10'(px.b);
            prod = 20'(sum) * 20'(RECIP3_Q11);
            gray3 = prod[18:11];
        end
    endfunction

    function automatic logic [23:0] pack_pixel(input rgb_t px, input pack_cfg_t cfg);
        logic [7:0] gray;
        begin
            gray = gray3(px);
            unique case (cfg.bpp)
                BPP_GRAY8:  pack_pixel = {16'd0, gray};
                BPP_GRAY16: pack_pixel = {8'd0, gray, 8'd0};
                BPP_RGB24,
                BPP_RGB32:
                begin
                    if (cfg.red_low)
                    begin
                        pack_pixel = {px.b, px.g, px.r};
                    end
                    else
                    begin
                        pack_pixel = {px.r, px.g, px.b};
                    end
                end
                default:    pack_pixel = 24'd0;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

/* sv/fpc_if.sv */
// ============================================================================
// fpc_in_if / fpc_out_if: stream channels of the pixel converter
// Valid/ready channels carrying source items and display pixel words.
// ============================================================================
`default_nettype none

interface fpc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] sample_a;
    logic [7:0] sample_b;
    logic [7:0] sample_c;
    logic [7:0] palette_slot;

    modport source (output valid, opcode, sample_a, sample_b, sample_c, palette_slot,
                    input ready);
    modport sink   (input valid, opcode, sample_a, sample_b, sample_c, palette_slot,
                    output ready);
endinterface

interface fpc_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_word;
    logic        last;

    modport source (output valid, pixel_word, last, input ready);
    modport sink   (input valid, pixel_word, last, output ready);
endinterface

`default_nettype wire

/* sv/fpc_palette.sv */
// ============================================================================
// fpc_palette: palette color table
// Single-port-write, registered-read memory of RGB palette entries.
// ============================================================================
`default_nettype none

module fpc_palette #(
    parameter int PALETTE_DEPTH = fpc_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             wr_en,
    input  wire logic [$clog2(PALETTE_DEPTH)-1:0] wr_addr,
    input  wire fpc_pkg::rgb_t                    wr_data,
    input  wire logic                             rd_en,
    input  wire logic [$clog2(PALETTE_DEPTH)-1:0] rd_addr,
    output fpc_pkg::rgb_t                         rd_data
);

    fpc_pkg::rgb_t mem [PALETTE_DEPTH];
    fpc_pkg::rgb_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* sv/fpc_color.sv */
// ============================================================================
// fpc_color: source color decode
// Turns a YUV, RGB or palette source item into one RGB triple.
// ============================================================================
`default_nettype none

module fpc_color (
    input  wire logic [1:0]    source_format,
    input  wire logic [7:0]    sample_a,
    input  wire logic [7:0]    sample_b,
    input  wire logic [7:0]    sample_c,
    input  wire fpc_pkg::rgb_t pal_data,
    input  wire logic          pal_hit,
    output fpc_pkg::rgb_t      rgb
);

    logic signed [8:0]  u;
    logic signed [8:0]  v;
    logic signed [27:0] y_q;
    logic signed [27:0] sum_r;
    logic signed [27:0] sum_g;
    logic signed [27:0] sum_b;
    fpc_pkg::rgb_t      yuv_rgb;

    function automatic logic [7:0] clamp_q16(input logic signed [27:0] s);
        begin
            if (s[27])
            begin
                clamp_q16 = 8'd0;
            end
            else if (s[26:24] != 3'd0)
            begin
                clamp_q16 = 8'hff;
            end
            else
            begin
                clamp_q16 = s[23:16];
            end
        end
    endfunction

    // The chroma products are formed at the full 28-bit sum width so that the
    // largest term, about 2^24 in magnitude, keeps its sign.
    always_comb
    begin
        u     = $signed({1'b0, sample_b}) - 9'sd128;
        v     = $signed({1'b0, sample_c}) - 9'sd128;
        y_q   = $signed({4'd0, sample_a, 16'd0});
        sum_r = y_q - 28'(u) * 28'(fpc_pkg::K_RU) + 28'(v) * 28'(fpc_pkg::K_RV);
        sum_g = y_q - 28'(u) * 28'(fpc_pkg::K_GU) - 28'(v) * 28'(fpc_pkg::K_GV);
        sum_b = y_q + 28'(u) * 28'(fpc_pkg::K_BU) - 28'(v) * 28'(fpc_pkg::K_BV);
        yuv_rgb.r = clamp_q16(sum_r);
        yuv_rgb.g = clamp_q16(sum_g);
        yuv_rgb.b = clamp_q16(sum_b);
    end

    always_comb
    begin
        unique case (source_format)
            fpc_pkg::FMT_YUV: rgb = yuv_rgb;
            fpc_pkg::FMT_RGB: rgb = '{r: sample_a, g: sample_b, b: sample_c};
            fpc_pkg::FMT_PALETTE:
            begin
                rgb = pal_hit ? pal_data : '0;
            end
            default:          rgb = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/fpc_out.sv */
// ============================================================================
// fpc_out: output packing and black-and-white serializer
// Packs RGB triples into pixel words and spreads a black-and-white byte over
// eight transfers.
// ============================================================================
`default_nettype none

module fpc_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire fpc_pkg::rgb_t      item_rgb,
    input  wire logic               item_bw,
    input  wire logic [7:0]         item_bits,
    input  wire fpc_pkg::pack_cfg_t cfg,
    output logic                    free,
    fpc_out_if.source               out_ch
);

    logic        valid_reg;
    logic        last_reg;
    logic [23:0] word_reg;
    logic [6:0]  bits_reg;
    logic [2:0]  cnt_reg;
    logic        xfer;
    logic        load;
    logic        step;

    function automatic fpc_pkg::rgb_t bw_rgb(input logic bit_val);
        begin
            bw_rgb = {3{bit_val ? 8'hff : 8'h00}};
        end
    endfunction

    assign xfer = valid_reg && out_ch.ready;
    // The register is free once the final word of the current item is taken.
    assign free = !valid_reg || (xfer && last_reg);
    assign load = free && item_valid;
    assign step = xfer && !last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            cnt_reg   <= 3'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            last_reg  <= !item_bw;
            cnt_reg   <= 3'd0;
        end
        else if (step)
        begin
            last_reg <= (cnt_reg == 3'd6);
            cnt_reg  <= cnt_reg + 3'd1;
        end
        else if (xfer)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= fpc_pkg::pack_pixel(item_bw ? bw_rgb(item_bits[0]) : item_rgb, cfg);
            bits_reg <= item_bits[7:1];
        end
        else if (step)
        begin
            word_reg <= fpc_pkg::pack_pixel(bw_rgb(bits_reg[0]), cfg);
            bits_reg <= {1'b0, bits_reg[6:1]};
        end
    end

    assign out_ch.valid      = valid_reg;
    assign out_ch.pixel_word = word_reg;
    assign out_ch.last       = last_reg;

endmodule

`default_nettype wire

/* sv/framebuffer_pixel_converter.sv */
// ============================================================================
// framebuffer_pixel_converter: frame-buffer source to display pixel words
// Converts YUV, RGB, palette or packed black-and-white source items into
// packed display pixels, with a loadable RGB palette.
// ============================================================================
`default_nettype none

// The converter takes one source item per clock while the output side is ready,
// and returns display pixel words through stage one, stage two and the output
// register. YUV, RGB and palette items give one word each, so the block sustains
// one item per cycle while the output is ready; a black-and-white item gives
// eight words, LSB first, from the single output register, so a run of such items
// stalls the input once the two stages ahead of that register are full. Palette
// write items give no word. The palette is a synchronous memory of PALETTE_DEPTH
// entries that starts undefined: every entry that is looked up must be written
// first. Configuration must only be written while no item is in flight.

module framebuffer_pixel_converter #(
    parameter int PALETTE_DEPTH = fpc_pkg::PALETTE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    fpc_in_if.sink          in_ch,
    fpc_out_if.source       out_ch,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_index,
    input  wire logic [2:0] cfg_data
);

    localparam int         ADDR_W    = $clog2(PALETTE_DEPTH);
    localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

    // Configuration registers.
    logic [1:0] fmt_reg;
    logic [2:0] bpp_reg;
    logic       be_reg;

    // Stage one: the captured input item, aligned with the palette read.
    logic       valid1_reg;
    logic       op1_reg;
    logic       hit1_reg;
    logic [7:0] a1_reg;
    logic [7:0] b1_reg;
    logic [7:0] c1_reg;

    // Stage two: the decoded RGB triple waiting for the output stage.
    logic          valid2_reg;
    fpc_pkg::rgb_t rgb2_reg;
    logic          bw2_reg;
    logic [7:0]    bits2_reg;

    logic          in_accept;
    logic          adv1;
    logic          out_free;
    logic          pal_wr_en;
    fpc_pkg::rgb_t pal_data;
    fpc_pkg::rgb_t rgb1;
    fpc_pkg::pack_cfg_t pack_cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= fpc_pkg::SOURCE_FORMAT_RST;
            bpp_reg <= fpc_pkg::OUT_BPP_RST;
            be_reg  <= fpc_pkg::RED_LOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fpc_pkg::CFG_SOURCE_FORMAT: fmt_reg <= cfg_data[1:0];
                fpc_pkg::CFG_OUT_BPP:       bpp_reg <= cfg_data;
                fpc_pkg::CFG_RED_LOW:       be_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // Stage two empties into the output stage once that stage has sent the
    // final word of its current item; stage one moves on whenever stage two
    // does, or takes a new item when it is empty itself.
    assign adv1         = !valid2_reg || out_free;
    assign in_ch.ready  = !valid1_reg || adv1;
    assign in_accept    = in_ch.valid && in_ch.ready;

    // Palette writes to slots beyond the table are dropped.
    assign pal_wr_en = in_accept && (in_ch.opcode == fpc_pkg::OP_PAL_WRITE)
                       && ({1'b0, in_ch.palette_slot} < DEPTH_LIM);

    fpc_palette #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr_en),
        .wr_addr (in_ch.palette_slot[ADDR_W-1:0]),
        .wr_data ({in_ch.sample_a, in_ch.sample_b, in_ch.sample_c}),
        .rd_en   (in_accept),
        .rd_addr (in_ch.sample_a[ADDR_W-1:0]),
        .rd_data (pal_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            valid1_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op1_reg  <= in_ch.opcode;
            // An index beyond the table reads as black.
            hit1_reg <= ({1'b0, in_ch.sample_a} < DEPTH_LIM);
            a1_reg   <= in_ch.sample_a;
            b1_reg   <= in_ch.sample_b;
            c1_reg   <= in_ch.sample_c;
        end
    end

    fpc_color u_color (
        .source_format (fmt_reg),
        .sample_a      (a1_reg),
        .sample_b      (b1_reg),
        .sample_c      (c1_reg),
        .pal_data      (pal_data),
        .pal_hit       (hit1_reg),
        .rgb           (rgb1)
    );

    // Palette writes leave the pipeline here; they give no word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
        end
        else if (adv1)
        begin
            valid2_reg <= valid1_reg && (op1_reg == fpc_pkg::OP_PIXEL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            rgb2_reg  <= rgb1;
            bw2_reg   <= (fmt_reg == fpc_pkg::FMT_BW);
            bits2_reg <= a1_reg;
        end
    end

    assign pack_cfg = '{bpp: bpp_reg, red_low: be_reg};

    fpc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (valid2_reg),
        .item_rgb   (rgb2_reg),
        .item_bw    (bw2_reg),
        .item_bits  (bits2_reg),
        .cfg        (pack_cfg),
        .free       (out_free),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire
